>>> rtl/bba_pkg.sv
package bba_pkg;

    localparam int MAX_DEPTH      = 5;
    localparam int MIN_BLOCK_LOG2 = 4;

    localparam int NODE_COUNT = (2 << MAX_DEPTH) - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
    localparam int POS_W      = MAX_DEPTH;

    localparam int CFG_W      = 3;
    localparam int REQ_W      = 2;
    localparam int SIZE_W     = 10;
    localparam int LEAF_W     = 5;
    localparam int RES_W      = 2;
    localparam int BYTES_W    = 10;
    localparam int L2_W       = 4;

    localparam int IN_TDATA_W  = ((SIZE_W + LEAF_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((LEAF_W + BYTES_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] POOL_ORDER_RST = CFG_W'(4);

    typedef enum logic [1:0] {
        ST_FREE,
        ST_PARTIAL,
        ST_FULL
    } t_node_st;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC,
        REQ_FREE,
        REQ_QUERY
    } t_req;

    typedef enum logic [RES_W-1:0] {
        RES_OK,
        RES_NOSPACE,
        RES_BADIDX
    } t_result;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        t_node_st          wdata;
        logic [NODE_W-1:0] raddr_a;
        logic [NODE_W-1:0] raddr_b;
    } t_mem_req;

    // heap index of the node at a level and position
    function automatic logic [NODE_W-1:0] f_node_idx(input logic [LVL_W-1:0] lvl,
                                                     input logic [POS_W-1:0] pos);
        logic [NODE_W-1:0] v_base;
        v_base = (NODE_W'(1) << lvl) - NODE_W'(1);
        return v_base + NODE_W'(pos);
    endfunction

    function automatic t_node_st f_merge(input t_node_st a, input t_node_st b);
        t_node_st v_st;
        if (a == ST_FREE && b == ST_FREE) begin
            v_st = ST_FREE;
        end else if (a == ST_FULL && b == ST_FULL) begin
            v_st = ST_FULL;
        end else begin
            v_st = ST_PARTIAL;
        end
        return v_st;
    endfunction

    // log2 of the block size, rounded up, at least the minimum block
    function automatic logic [L2_W-1:0] f_size_log2(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] v_m;
        logic [L2_W-1:0]   v_r;
        v_m = v - SIZE_W'(1);
        v_r = '0;
        if (v > SIZE_W'(1)) begin
            for (int i = 0; i < SIZE_W; i++) begin
                if (v_m[i]) begin
                    v_r = L2_W'(i + 1);
                end
            end
        end
        if (v_r < L2_W'(MIN_BLOCK_LOG2)) begin
            v_r = L2_W'(MIN_BLOCK_LOG2);
        end
        return v_r;
    endfunction

endpackage

>>> rtl/bba_node_mem.sv
module bba_node_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bba_pkg::t_mem_req  i_req,
    output bba_pkg::t_node_st  o_rd_a,
    output bba_pkg::t_node_st  o_rd_b
);
    import bba_pkg::*;

    t_node_st              r_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_vld;
    t_node_st              r_rd_a;
    t_node_st              r_rd_b;
    logic                  r_rd_a_vld;
    logic                  r_rd_b_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.waddr < NODE_W'(NODE_COUNT)) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.raddr_a < NODE_W'(NODE_COUNT)) begin
            r_rd_a <= r_mem[i_req.raddr_a];
        end
        if (i_req.raddr_b < NODE_W'(NODE_COUNT)) begin
            r_rd_b <= r_mem[i_req.raddr_b];
        end
    end

    // entries never written read as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_a_vld <= 1'b0;
            r_rd_b_vld <= 1'b0;
        end else begin
            if (i_req.we && i_req.waddr < NODE_W'(NODE_COUNT)) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rd_a_vld <= (i_req.raddr_a < NODE_W'(NODE_COUNT)) ? r_vld[i_req.raddr_a] : 1'b0;
            r_rd_b_vld <= (i_req.raddr_b < NODE_W'(NODE_COUNT)) ? r_vld[i_req.raddr_b] : 1'b0;
        end
    end

    assign o_rd_a = r_rd_a_vld ? r_rd_a : ST_FREE;
    assign o_rd_b = r_rd_b_vld ? r_rd_b : ST_FREE;

endmodule

>>> rtl/bba_ctrl.sv
module bba_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bba_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bba_pkg::REQ_W-1:0]        i_req_type,
    input  logic [bba_pkg::SIZE_W-1:0]       i_size_bytes,
    input  logic [bba_pkg::LEAF_W-1:0]       i_leaf_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bba_pkg::OUT_TDATA_W-1:0]  o_out_tdata,
    output logic [bba_pkg::RES_W-1:0]        o_out_tuser,
    output bba_pkg::t_mem_req                o_mem,
    input  bba_pkg::t_node_st                i_rd_a,
    input  bba_pkg::t_node_st                i_rd_b
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DFS,
        S_ASC,
        S_FXA,
        S_FXB,
        S_UP,
        S_DONE
    } t_state;

    t_state                  r_state,     n_state;
    logic [CFG_W-1:0]        r_order,     n_order;
    logic [REQ_W-1:0]        r_req,       n_req;
    logic [LVL_W-1:0]        r_tgt,       n_tgt;
    logic [LVL_W-1:0]        r_lvl,       n_lvl;
    logic [POS_W-1:0]        r_pos,       n_pos;
    t_result                 r_res,       n_res;
    logic [LEAF_W-1:0]       r_leaf,      n_leaf;
    logic [BYTES_W-1:0]      r_bytes,     n_bytes;
    logic                    r_out_vld,   n_out_vld;
    logic [OUT_TDATA_W-1:0]  r_out_tdata, n_out_tdata;
    logic [RES_W-1:0]        r_out_tuser, n_out_tuser;

    logic [LVL_W-1:0]  w_order;
    logic [L2_W-1:0]   w_l2;
    logic [L2_W-1:0]   w_cap;
    logic [L2_W-1:0]   w_sh;
    logic [POS_W-1:0]  w_pair;

    assign w_order = (r_order > CFG_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : LVL_W'(r_order);
    assign w_l2    = f_size_log2(i_size_bytes);
    assign w_cap   = L2_W'(w_order) + L2_W'(MIN_BLOCK_LOG2);
    assign w_sh    = L2_W'(w_order) - L2_W'(r_lvl) + L2_W'(MIN_BLOCK_LOG2);
    assign w_pair  = {r_pos[POS_W-1:1], 1'b0};

    always_comb begin
        n_state     = r_state;
        n_order     = i_cfg_we ? i_cfg_wdata : r_order;
        n_req       = r_req;
        n_tgt       = r_tgt;
        n_lvl       = r_lvl;
        n_pos       = r_pos;
        n_res       = r_res;
        n_leaf      = r_leaf;
        n_bytes     = r_bytes;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_out_tdata = r_out_tdata;
        n_out_tuser = r_out_tuser;
        o_mem.we    = 1'b0;
        o_mem.waddr = f_node_idx(r_lvl, r_pos);
        o_mem.wdata = ST_FREE;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_req_type;
                    n_leaf  = '0;
                    n_bytes = '0;
                    if (i_req_type == REQ_ALLOC) begin
                        if (w_l2 > w_cap) begin
                            n_res   = RES_NOSPACE;
                            n_state = S_DONE;
                        end else begin
                            n_tgt   = LVL_W'(w_cap - w_l2);
                            n_lvl   = '0;
                            n_pos   = '0;
                            n_state = S_DFS;
                        end
                    end else if (i_req_type == REQ_FREE || i_req_type == REQ_QUERY) begin
                        if ((LEAF_W + 1)'(i_leaf_index) >= ((LEAF_W + 1)'(1) << w_order)) begin
                            n_res   = RES_BADIDX;
                            n_state = S_DONE;
                        end else begin
                            n_lvl   = w_order;
                            n_pos   = POS_W'(i_leaf_index);
                            n_state = S_UP;
                        end
                    end else begin
                        n_res   = RES_BADIDX;
                        n_state = S_DONE;
                    end
                end
            end
            S_DFS: begin
                if (r_lvl != r_tgt && i_rd_a != ST_FULL) begin
                    n_lvl = r_lvl + LVL_W'(1);
                    n_pos = {r_pos[POS_W-2:0], 1'b0};
                end else if (r_lvl == r_tgt && i_rd_a == ST_FREE) begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = ST_FULL;
                    n_res       = RES_OK;
                    n_leaf      = LEAF_W'(r_pos << (w_order - r_tgt));
                    n_state     = (r_lvl == '0) ? S_DONE : S_FXA;
                end else if (r_lvl == '0) begin
                    n_res   = RES_NOSPACE;
                    n_state = S_DONE;
                end else if (!r_pos[0]) begin
                    n_pos = r_pos + POS_W'(1);
                end else begin
                    n_lvl   = r_lvl - LVL_W'(1);
                    n_pos   = r_pos >> 1;
                    n_state = S_ASC;
                end
            end
            S_ASC: begin
                if (r_lvl == '0) begin
                    n_res   = RES_NOSPACE;
                    n_state = S_DONE;
                end else if (!r_pos[0]) begin
                    n_pos   = r_pos + POS_W'(1);
                    n_state = S_DFS;
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                    n_pos = r_pos >> 1;
                end
            end
            S_FXA: begin
                n_state = S_FXB;
            end
            S_FXB: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = f_node_idx(r_lvl - LVL_W'(1), r_pos >> 1);
                o_mem.wdata = f_merge(i_rd_a, i_rd_b);
                n_lvl       = r_lvl - LVL_W'(1);
                n_pos       = r_pos >> 1;
                n_state     = (r_lvl == LVL_W'(1)) ? S_DONE : S_FXA;
            end
            S_UP: begin
                if (i_rd_a == ST_FULL) begin
                    n_res = RES_OK;
                    if (r_req == REQ_FREE) begin
                        o_mem.we    = 1'b1;
                        o_mem.wdata = ST_FREE;
                        n_state     = (r_lvl == '0) ? S_DONE : S_FXA;
                    end else begin
                        n_bytes = BYTES_W'(1) << w_sh;
                        n_state = S_DONE;
                    end
                end else if (r_lvl == '0) begin
                    n_res   = RES_BADIDX;
                    n_state = S_DONE;
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                    n_pos = r_pos >> 1;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld   = 1'b1;
                    n_out_tdata = OUT_TDATA_W'({r_bytes, r_leaf});
                    n_out_tuser = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // read port a follows the next node, except while fetching a sibling pair
        o_mem.raddr_a = (r_state == S_FXA) ? f_node_idx(r_lvl, w_pair)
                                           : f_node_idx(n_lvl, n_pos);
        o_mem.raddr_b = f_node_idx(r_lvl, w_pair | POS_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_order   <= POOL_ORDER_RST;
            r_lvl     <= '0;
            r_pos     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_order   <= n_order;
            r_lvl     <= n_lvl;
            r_pos     <= n_pos;
            r_out_vld <= n_out_vld;
        end
        r_req       <= n_req;
        r_tgt       <= n_tgt;
        r_res       <= n_res;
        r_leaf      <= n_leaf;
        r_bytes     <= n_bytes;
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_tdata = r_out_tdata;
    assign o_out_tuser = r_out_tuser;

endmodule

>>> rtl/buddy_block_allocator_unit.sv
// channel | dir | handshake                    | payload
// s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata: size_bytes, leaf_index; tuser: req_type
// m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: block_leaf, block_bytes; tuser: status
// cfg     | in  | i_cfg_we                     | i_cfg_wdata: pool_order
//
// one request at a time; each step reads one node of the status memory, or a sibling
// pair for an ancestor rewrite; allocate: depth-first search and climbing back, then
// the ancestors rewritten; free: walk up to the full block, then the ancestors
// rewritten; query: walk up to the full block; the result is then posted
// node status clears to free at reset through per-node valid bits, no sweep
// a waiting result sits in the output register while the next request is taken
module buddy_block_allocator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bba_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // size_bytes, leaf_index
    input  logic [bba_pkg::REQ_W-1:0]        s_axis_tuser,   // req_type
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // block_leaf, block_bytes
    output logic [bba_pkg::RES_W-1:0]        m_axis_tuser    // result_status
);
    import bba_pkg::*;

    t_mem_req  w_mem;
    t_node_st  w_rd_a;
    t_node_st  w_rd_b;

    bba_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_size_bytes (s_axis_tdata[SIZE_W-1:0]),
        .i_leaf_index (s_axis_tdata[SIZE_W+LEAF_W-1:SIZE_W]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tuser  (m_axis_tuser),
        .o_mem        (w_mem),
        .i_rd_a       (w_rd_a),
        .i_rd_b       (w_rd_b)
    );

    bba_node_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem),
        .o_rd_a  (w_rd_a),
        .o_rd_b  (w_rd_b)
    );

endmodule

>>> rtl/bba_chk.sv
module bba_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [bba_pkg::RES_W-1:0]        m_axis_tuser
);
    import bba_pkg::*;

    // a result held back keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == RES_OK || m_axis_tuser == RES_NOSPACE ||
                           m_axis_tuser == RES_BADIDX))
        else $error("undefined status code");

    // failed requests carry no leaf or size
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != RES_OK |-> m_axis_tdata == '0)
        else $error("payload on failed request");

endmodule

bind buddy_block_allocator_unit bba_chk u_bba_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 90;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // size_bytes, leaf_index
    logic [REQ_W-1:0]       s_axis_tuser = '0;   // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // block_leaf, block_bytes
    logic [RES_W-1:0]       m_axis_tuser;        // result_status

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int phase_orders [8] = '{5, 2, 7, 0, 4, 1, 6, 3};

    typedef struct {
        t_result             status;
        logic [LEAF_W-1:0]   leaf;
        logic [BYTES_W-1:0]  bytes;
    } t_reply;

    class buddy_tracker;
        t_node_st     node_st [NODE_COUNT];
        int           pool_order;
        t_reply       replies_due [$];
        int           mismatches;

        function new();
            foreach (node_st[n]) node_st[n] = ST_FREE;
            pool_order = int'(POOL_ORDER_RST);
            mismatches = 0;
        endfunction

        function int order_in_use();
            return (pool_order > MAX_DEPTH) ? MAX_DEPTH : pool_order;
        endfunction

        function int level_of(int node);
            int lvl;
            int v;
            lvl = 0;
            v = node + 1;
            while (v > 1) begin
                v = v >> 1;
                lvl++;
            end
            return lvl;
        endfunction

        function void refresh_parents(int node);
            int p;
            while (node > 0) begin
                p = (node - 1) / 2;
                if (node_st[2*p+1] == ST_FREE && node_st[2*p+2] == ST_FREE) begin
                    node_st[p] = ST_FREE;
                end else if (node_st[2*p+1] == ST_FULL && node_st[2*p+2] == ST_FULL) begin
                    node_st[p] = ST_FULL;
                end else begin
                    node_st[p] = ST_PARTIAL;
                end
                node = p;
            end
        endfunction

        function bit covered_by_full(int node);
            while (node > 0) begin
                node = (node - 1) / 2;
                if (node_st[node] == ST_FULL) return 1'b1;
            end
            return 1'b0;
        endfunction

        // nearest full node at or above a leaf, -1 when none
        function int holder_of(int leaf, int ord);
            int node;
            node = (1 << ord) - 1 + leaf;
            while (node > 0 && node_st[node] != ST_FULL) node = (node - 1) / 2;
            return (node_st[node] == ST_FULL) ? node : -1;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [SIZE_W-1:0] size,
                                   logic [LEAF_W-1:0] leaf);
            t_reply want;
            int ord;
            int l2;
            int lvl;
            int base;
            int node;
            int k;
            ord = order_in_use();
            want.status = RES_BADIDX;
            want.leaf = '0;
            want.bytes = '0;
            if (req == REQ_ALLOC) begin
                want.status = RES_NOSPACE;
                l2 = MIN_BLOCK_LOG2;
                while ((1 << l2) < int'(size)) l2++;
                if (l2 <= ord + MIN_BLOCK_LOG2) begin
                    lvl = ord + MIN_BLOCK_LOG2 - l2;
                    base = (1 << lvl) - 1;
                    for (k = 0; k < (1 << lvl) && want.status != RES_OK; k++) begin
                        node = base + k;
                        if (node_st[node] == ST_FREE && !covered_by_full(node)) begin
                            node_st[node] = ST_FULL;
                            refresh_parents(node);
                            want.status = RES_OK;
                            want.leaf = LEAF_W'(k << (ord - lvl));
                        end
                    end
                end
            end else if (req == REQ_FREE || req == REQ_QUERY) begin
                node = -1;
                if (int'(leaf) < (1 << ord)) node = holder_of(int'(leaf), ord);
                if (node >= 0) begin
                    want.status = RES_OK;
                    if (req == REQ_FREE) begin
                        node_st[node] = ST_FREE;
                        refresh_parents(node);
                    end else begin
                        want.bytes = BYTES_W'(1 << (ord - level_of(node) + MIN_BLOCK_LOG2));
                    end
                end
            end
            replies_due.push_back(want);
        endfunction

        // a leaf inside some full block under the current order, -1 when none
        function int busy_leaf(bit spread);
            int ord;
            int lvl;
            int span;
            int first;
            int hits [$];
            ord = order_in_use();
            for (int n = 0; n < (2 << ord) - 1; n++) begin
                if (node_st[n] == ST_FULL) begin
                    lvl = level_of(n);
                    span = 1 << (ord - lvl);
                    first = (n - ((1 << lvl) - 1)) * span;
                    hits.push_back(spread ? first + int'($urandom_range(span - 1)) : first);
                end
            end
            if (hits.size() == 0) return -1;
            return hits[$urandom_range(hits.size() - 1)];
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_reply(logic [RES_W-1:0] status, logic [LEAF_W-1:0] leaf,
                         logic [BYTES_W-1:0] bytes);
            t_reply want;
            if (replies_due.size() == 0) begin
                report($sformatf("reply with no request outstanding, status %0d", status));
            end else begin
                want = replies_due.pop_front();
                if (status !== want.status)
                    report($sformatf("status got %0d expected %0d", status, want.status));
                if (leaf !== want.leaf)
                    report($sformatf("block_leaf got %0d expected %0d", leaf, want.leaf));
                if (bytes !== want.bytes)
                    report($sformatf("block_bytes got %0d expected %0d", bytes, want.bytes));
            end
        endtask
    endclass

    buddy_tracker sb;

    buddy_block_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [SIZE_W-1:0] size,
                                input logic [LEAF_W-1:0] leaf);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= IN_TDATA_W'({leaf, size});
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, size, leaf);
        @(negedge i_clk);
    endtask

    task automatic write_order(input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.replies_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.pool_order = int'(value);
    endtask

    // receiver: random stalls plus a long hold-off on request
    initial begin
        int hold_left;
        int seen;
        hold_left = 0;
        seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != seen) begin
                seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_reply(m_axis_tuser, m_axis_tdata[LEAF_W-1:0],
                               m_axis_tdata[LEAF_W +: BYTES_W]);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("buddy_block_allocator_unit verification failed");
        $finish;
    end

    initial begin
        int p;
        int i;
        int ord;
        int roll;
        int pick;
        int l2;
        logic [SIZE_W-1:0] size;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset order: basic alloc, query, free and error cases
        send_request(REQ_ALLOC, 10'd0, 5'd0);
        send_request(REQ_QUERY, 10'd0, 5'd0);
        send_request(REQ_ALLOC, 10'd1023, 5'd0);
        send_request(REQ_ALLOC, 10'd17, 5'd0);
        send_request(REQ_ALLOC, 10'd256, 5'd0);
        send_request(REQ_FREE, 10'd0, 5'd1);
        send_request(REQ_QUERY, 10'd0, 5'd31);
        send_request(REQ_UNKNOWN, 10'd1023, 5'd31);
        send_request(REQ_FREE, 10'd0, 5'd0);
        send_request(REQ_FREE, 10'd0, 5'd3);
        send_request(REQ_ALLOC, 10'd256, 5'd0);
        send_request(REQ_QUERY, 10'd0, 5'd15);
        send_request(REQ_ALLOC, 10'd16, 5'd0);
        send_request(REQ_FREE, 10'd0, 5'd7);
        // single block pool
        write_order(3'd0);
        send_request(REQ_ALLOC, 10'd16, 5'd0);
        send_request(REQ_ALLOC, 10'd16, 5'd0);
        send_request(REQ_QUERY, 10'd0, 5'd0);
        send_request(REQ_FREE, 10'd0, 5'd0);
        // order above the maximum depth
        write_order(3'd7);
        send_request(REQ_ALLOC, 10'd512, 5'd0);
        send_request(REQ_QUERY, 10'd0, 5'd31);
        send_request(REQ_ALLOC, 10'd16, 5'd0);
        send_request(REQ_FREE, 10'd0, 5'd31);
        send_request(REQ_ALLOC, 10'd1, 5'd0);
        // tree kept across an order change
        write_order(3'd4);
        send_request(REQ_QUERY, 10'd0, 5'd0);
        send_request(REQ_ALLOC, 10'd16, 5'd0);

        for (p = 0; p < 8; p++) begin
            write_order(CFG_W'(phase_orders[p]));
            case (p % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 79;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 79;
                end
                default: begin
                    src_idle_pct = 6;
                    sink_stall_pct = 6;
                end
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 0 && i == 10) hold_requests <= hold_requests + 1;
                ord = sb.order_in_use();
                roll = $urandom_range(99);
                pick = sb.busy_leaf(1'b1);
                if (pick < 0 || $urandom_range(9) == 0) pick = $urandom_range((1 << ord) - 1);
                if (roll < 45) begin
                    if ($urandom_range(9) == 0) begin
                        size = SIZE_W'($urandom_range(1023));
                    end else begin
                        l2 = $urandom_range(MIN_BLOCK_LOG2 + ord, MIN_BLOCK_LOG2);
                        if (l2 == MIN_BLOCK_LOG2)
                            size = SIZE_W'($urandom_range(1 << l2, 0));
                        else
                            size = SIZE_W'($urandom_range(1 << l2, (1 << (l2 - 1)) + 1));
                    end
                    send_request(REQ_ALLOC, size, LEAF_W'($urandom_range(31)));
                end else if (roll < 80) begin
                    send_request(REQ_FREE, SIZE_W'($urandom_range(1023)), LEAF_W'(pick));
                end else if (roll < 95) begin
                    send_request(REQ_QUERY, SIZE_W'($urandom_range(1023)), LEAF_W'(pick));
                end else begin
                    send_request(REQ_W'($urandom_range(3)), SIZE_W'($urandom_range(1023)),
                                 LEAF_W'($urandom_range(31)));
                end
            end
            // release what is visible, except after the first phase to keep stale blocks
            if (p != 0) begin
                for (i = 0; i < 64; i++) begin
                    pick = sb.busy_leaf(1'b0);
                    if (pick < 0) break;
                    send_request(REQ_FREE, SIZE_W'($urandom_range(1023)), LEAF_W'(pick));
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.replies_due.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.replies_due.size() == 0)
            $display("buddy_block_allocator_unit verification clean");
        else
            $display("buddy_block_allocator_unit verification failed");
        $finish;
    end

endmodule
